FILE: design/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

   // Fixed widths of the transaction fields.
   localparam int ADDR_W            = 32;
   localparam int OP_W              = 2;
   localparam int STATUS_W          = 3;
   localparam int ROUTE_INDEX_W     = 10;

   // Default sizing of the table and of the compare chain.
   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_NUM_CELLS   = 16;

   // Operation codes of an input transaction.
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   // Status codes of a result transaction.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_CLEARED  = 3'd0,
      STATUS_APPENDED = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_FOUND    = 3'd3,
      STATUS_NO_ROUTE = 3'd4
   } status_type;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SWEEP = 2'd1,
      ST_WAIT  = 2'd2
   } state_type;

   // Control that travels with each row bundle along the chain.
   typedef struct packed {
      logic valid;
      logic last;
   } chain_ctl_type;

endpackage : lpm_pkg

`default_nettype wire

FILE: design/longest_prefix_match_table_unit.sv
`default_nettype none

// IPv4 longest-prefix-match route table.
// A transaction is taken when start is high and busy is low. req_op selects
// clear, append (req_entry_prefix, req_entry_mask) or lookup (req_dest_addr).
// Every transaction gives exactly one result: rsp_valid is high for one cycle
// with rsp_status and rsp_route_index, and the receiver cannot hold it off.
// Clear, append, table full and the unused op code answer in the cycle after
// acceptance, and busy stays low, so these may follow back to back.
// A lookup raises busy and sweeps the table row by row: entries are spread
// over NUM_CELLS banks, each a cell of a chain that compares one entry per
// row and passes the best candidate to its neighbor; a merge at the chain's
// end keeps the best over all rows. One row enters the chain per cycle and
// each cell has two register stages; the result is registered once the last
// row has left the chain, and busy falls at the same edge. A lookup on an
// empty table answers at once.
// Reset empties the table (entry count zero) and returns to idle; the stored
// pairs are not cleared since only entries below the count are ever used.
// NUM_CELLS is a power of two of at least two.
module longest_prefix_match_table_unit
   import lpm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int NUM_CELLS   = DEFAULT_NUM_CELLS
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire [OP_W-1:0]            req_op,
   input  wire [ADDR_W-1:0]          req_entry_prefix,
   input  wire [ADDR_W-1:0]          req_entry_mask,
   input  wire [ADDR_W-1:0]          req_dest_addr,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [ROUTE_INDEX_W-1:0]  rsp_route_index
);

   localparam int ROWS   = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CELL_W = $clog2(NUM_CELLS);
   localparam int CIDX_W = ROW_W + CELL_W;
   localparam int CNT_W  = CIDX_W + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    last_row_ff, last_row_in;
   logic [ADDR_W-1:0]   dest_ff, dest_in;
   logic                best_found_ff, best_found_in;
   logic [ADDR_W-1:0]   best_mask_ff, best_mask_in;
   logic [CIDX_W-1:0]   best_index_ff, best_index_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ROUTE_INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic                accept;
   op_type              req_op_code;
   logic                append_ok;
   logic                lookup_go;
   logic                chain_done;
   logic [NUM_CELLS-1:0] wr_en;
   logic [ROW_W-1:0]    wr_row;
   logic [CNT_W-1:0]    count_less;

   // Chain links; link c feeds cell c, link NUM_CELLS leaves the last cell.
   chain_ctl_type       link_ctl   [NUM_CELLS+1];
   logic [ROW_W-1:0]    link_row   [NUM_CELLS+1];
   logic [ADDR_W-1:0]   link_dest  [NUM_CELLS+1];
   logic                link_found [NUM_CELLS+1];
   logic [ADDR_W-1:0]   link_mask  [NUM_CELLS+1];
   logic [CIDX_W-1:0]   link_index [NUM_CELLS+1];

   // Merge of the chain output into the best over all rows.
   logic                merge_take;
   logic                merged_found;
   logic [ADDR_W-1:0]   merged_mask;
   logic [CIDX_W-1:0]   merged_index;

   assign accept      = start && (state_ff == ST_IDLE);
   assign req_op_code = op_type'(req_op);
   assign append_ok   = accept && (req_op_code == OP_APPEND) && (count_ff < DEPTH_CNT);
   assign lookup_go   = accept && (req_op_code == OP_LOOKUP) && (count_ff != '0);
   assign chain_done  = link_ctl[NUM_CELLS].valid && link_ctl[NUM_CELLS].last;
   assign count_less  = count_ff - CNT_W'(1);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (lookup_go) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (row_ff == last_row_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (chain_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Row sweep injected into the head of the chain.
   always_comb begin
      link_ctl[0].valid = (state_ff == ST_SWEEP);
      link_ctl[0].last  = (row_ff == last_row_ff);
      link_row[0]       = row_ff;
      link_dest[0]      = dest_ff;
      link_found[0]     = 1'b0;
      link_mask[0]      = '0;
      link_index[0]     = '0;
   end

   // Merge at the tail: a later row replaces only on a strictly greater mask.
   always_comb begin
      merge_take   = link_found[NUM_CELLS] &&
                     (!best_found_ff || (link_mask[NUM_CELLS] > best_mask_ff));
      merged_found = best_found_ff || link_found[NUM_CELLS];
      merged_mask  = merge_take ? link_mask[NUM_CELLS] : best_mask_ff;
      merged_index = merge_take ? link_index[NUM_CELLS] : best_index_ff;
   end

   // Table writes go to the bank chosen by the low bits of the count.
   assign wr_row = ROW_W'(count_ff >> CELL_W);
   always_comb begin
      for (int c = 0; c < NUM_CELLS; c++) begin
         wr_en[c] = append_ok && (count_ff[CELL_W-1:0] == CELL_W'(c));
      end
   end

   // Outputs and datapath next values of the sequencer.
   always_comb begin
      count_in      = count_ff;
      row_in        = row_ff;
      last_row_in   = last_row_ff;
      dest_in       = dest_ff;
      best_found_in = best_found_ff;
      best_mask_in  = best_mask_ff;
      best_index_in = best_index_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_NO_ROUTE;
      rsp_index_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            row_in        = '0;
            last_row_in   = ROW_W'(count_less >> CELL_W);
            dest_in       = req_dest_addr;
            best_found_in = 1'b0;
            best_mask_in  = '0;
            best_index_in = '0;
            if (accept && !lookup_go) begin
               rsp_valid_in = 1'b1;
               case (req_op_code)
                  OP_CLEAR: begin
                     count_in      = '0;
                     rsp_status_in = STATUS_CLEARED;
                  end
                  OP_APPEND: begin
                     if (append_ok) begin
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STATUS_APPENDED;
                        rsp_index_in  = ROUTE_INDEX_W'(count_ff);
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_NO_ROUTE;
                  end
               endcase
            end
         end
         ST_SWEEP, ST_WAIT: begin
            if (state_ff == ST_SWEEP) begin
               row_in = row_ff + ROW_W'(1);
            end
            if (link_ctl[NUM_CELLS].valid) begin
               best_found_in = merged_found;
               best_mask_in  = merged_mask;
               best_index_in = merged_index;
            end
            if (chain_done) begin
               rsp_valid_in = 1'b1;
               if (merged_found) begin
                  rsp_status_in = STATUS_FOUND;
                  rsp_index_in  = ROUTE_INDEX_W'(merged_index);
               end else begin
                  rsp_status_in = STATUS_NO_ROUTE;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      last_row_ff   <= last_row_in;
      dest_ff       <= dest_in;
      best_found_ff <= best_found_in;
      best_mask_ff  <= best_mask_in;
      best_index_ff <= best_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // The chain of table banks.
   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      lpm_cell #(
         .ROWS    (ROWS),
         .ROW_W   (ROW_W),
         .CELL_W  (CELL_W),
         .CELL_ID (c)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .wr_en       (wr_en[c]),
         .wr_row      (wr_row),
         .wr_prefix   (req_entry_prefix),
         .wr_mask     (req_entry_mask),
         .entry_count (count_ff),
         .in_ctl      (link_ctl[c]),
         .in_row      (link_row[c]),
         .in_dest     (link_dest[c]),
         .in_found    (link_found[c]),
         .in_mask     (link_mask[c]),
         .in_index    (link_index[c]),
         .out_ctl     (link_ctl[c+1]),
         .out_row     (link_row[c+1]),
         .out_dest    (link_dest[c+1]),
         .out_found   (link_found[c+1]),
         .out_mask    (link_mask[c+1]),
         .out_index   (link_index[c+1])
      );
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_route_index = rsp_index_ff;

endmodule : longest_prefix_match_table_unit

`default_nettype wire

FILE: design/lpm_cell.sv
`default_nettype none

// One bank of the route table plus its compare stage. Entry index is
// row * NUM_CELLS + CELL_ID. A row bundle arrives from the left neighbor,
// the bank is read in the first stage, and the entry is compared against
// the running best candidate in the second stage before the bundle moves on.
module lpm_cell
   import lpm_pkg::*;
#(
   parameter int ROWS    = 64,
   parameter int ROW_W   = 6,
   parameter int CELL_W  = 4,
   parameter int CELL_ID = 0
) (
   input  wire                          clock,
   input  wire                          reset,
   // Write port of the bank.
   input  wire                          wr_en,
   input  wire [ROW_W-1:0]              wr_row,
   input  wire [ADDR_W-1:0]             wr_prefix,
   input  wire [ADDR_W-1:0]             wr_mask,
   // Number of live entries in the whole table.
   input  wire [ROW_W+CELL_W:0]         entry_count,
   // Bundle from the left neighbor.
   input  chain_ctl_type                in_ctl,
   input  wire [ROW_W-1:0]              in_row,
   input  wire [ADDR_W-1:0]             in_dest,
   input  wire                          in_found,
   input  wire [ADDR_W-1:0]             in_mask,
   input  wire [ROW_W+CELL_W-1:0]       in_index,
   // Bundle to the right neighbor.
   output chain_ctl_type                out_ctl,
   output logic [ROW_W-1:0]             out_row,
   output logic [ADDR_W-1:0]            out_dest,
   output logic                         out_found,
   output logic [ADDR_W-1:0]            out_mask,
   output logic [ROW_W+CELL_W-1:0]      out_index
);

   localparam int CIDX_W = ROW_W + CELL_W;

   logic [ADDR_W-1:0]  prefix_mem [ROWS];
   logic [ADDR_W-1:0]  mask_mem   [ROWS];

   logic [ADDR_W-1:0]  rd_prefix_ff;
   logic [ADDR_W-1:0]  rd_mask_ff;
   chain_ctl_type      a_ctl_ff;
   logic [ROW_W-1:0]   a_row_ff;
   logic [ADDR_W-1:0]  a_dest_ff;
   logic               a_found_ff;
   logic [ADDR_W-1:0]  a_mask_ff;
   logic [CIDX_W-1:0]  a_index_ff;

   chain_ctl_type      b_ctl_ff;
   logic [ROW_W-1:0]   b_row_ff;
   logic [ADDR_W-1:0]  b_dest_ff;
   logic               b_found_ff;
   logic [ADDR_W-1:0]  b_mask_ff;
   logic [CIDX_W-1:0]  b_index_ff;

   logic [CIDX_W-1:0]  entry_index;
   logic               entry_live;
   logic               entry_hit;
   logic               entry_take;
   logic               b_found_in;
   logic [ADDR_W-1:0]  b_mask_in;
   logic [CIDX_W-1:0]  b_index_in;

   // Bank write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prefix_mem[wr_row] <= wr_prefix;
         mask_mem[wr_row]   <= wr_mask;
      end
      rd_prefix_ff <= prefix_mem[in_row];
      rd_mask_ff   <= mask_mem[in_row];
   end

   // First stage holds the bundle while the bank is read.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= in_ctl;
      end
      a_row_ff   <= in_row;
      a_dest_ff  <= in_dest;
      a_found_ff <= in_found;
      a_mask_ff  <= in_mask;
      a_index_ff <= in_index;
   end

   // Compare the entry and keep the better candidate. A strictly greater
   // mask is needed to replace, so the lower index wins a tie.
   always_comb begin
      entry_index = {a_row_ff, CELL_W'(CELL_ID)};
      entry_live  = {1'b0, entry_index} < entry_count;
      entry_hit   = entry_live && ((a_dest_ff & rd_mask_ff) == rd_prefix_ff);
      entry_take  = entry_hit && (!a_found_ff || (rd_mask_ff > a_mask_ff));
      b_found_in  = a_found_ff || entry_hit;
      b_mask_in   = entry_take ? rd_mask_ff : a_mask_ff;
      b_index_in  = entry_take ? entry_index : a_index_ff;
   end

   // Second stage hands the bundle to the neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else begin
         b_ctl_ff <= a_ctl_ff;
      end
      b_row_ff   <= a_row_ff;
      b_dest_ff  <= a_dest_ff;
      b_found_ff <= b_found_in;
      b_mask_ff  <= b_mask_in;
      b_index_ff <= b_index_in;
   end

   assign out_ctl   = b_ctl_ff;
   assign out_row   = b_row_ff;
   assign out_dest  = b_dest_ff;
   assign out_found = b_found_ff;
   assign out_mask  = b_mask_ff;
   assign out_index = b_index_ff;

endmodule : lpm_cell

`default_nettype wire
